### rtl/adj_pkg.sv
`timescale 1ns / 1ps

package adj_pkg;

   localparam int NUM_VERTICES  = 16;
   localparam int MAX_NEIGHBORS = 15;
   localparam int RESULT_LIMIT  = 15;

   localparam int VID_W       = 8;
   localparam int RC_W        = 4;
   localparam int ROW_W       = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int CNT_W       = $clog2(MAX_NEIGHBORS + 1);
   localparam int TABLE_DEPTH = NUM_VERTICES * MAX_NEIGHBORS;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic {
      OP_ADD_EDGE = 1'b0,
      OP_READ_ROW = 1'b1
   } adj_op_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [VID_W-1:0]  wdata;
   } mem_req_type;

   function automatic logic vertex_valid(input logic [VID_W-1:0] v);
      return (v != '0) && (32'(v) <= NUM_VERTICES);
   endfunction

   function automatic logic [ROW_W-1:0] vertex_row(input logic [VID_W-1:0] v);
      return ROW_W'(v - VID_W'(1));
   endfunction

   // Row r occupies MAX_NEIGHBORS consecutive words of the neighbor store.
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                    input logic [CNT_W-1:0] idx);
      return ADDR_W'(int'(row) * MAX_NEIGHBORS + int'(idx));
   endfunction

endpackage

### rtl/adj_mem.sv
`timescale 1ns / 1ps

module adj_mem
   import adj_pkg::*;
(
   input  logic                 clock,
   input  mem_req_type          mem_req,
   output logic [VID_W-1:0]     rd_data
);

   logic [VID_W-1:0] store_mem [TABLE_DEPTH];
   logic [VID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= store_mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/adj_core.sv
`timescale 1ns / 1ps

module adj_core
   import adj_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [VID_W-1:0]     req_vertex_a,
   input  logic [VID_W-1:0]     req_vertex_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VID_W-1:0]     rsp_neighbor,
   output logic [RC_W-1:0]      rsp_row_count,
   output logic                 rsp_last,
   output logic                 rsp_added_to_a,
   output logic                 rsp_added_to_b,
   output logic                 rsp_row_full,
   output mem_req_type          mem_req,
   input  logic [VID_W-1:0]     rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_START,
      ST_RD_DATA,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [VID_W-1:0] a_ff, a_in;
   logic [VID_W-1:0] b_ff, b_in;
   logic             phase_ff, phase_in;
   logic [VID_W-1:0] cur_v_ff, cur_v_in;
   logic [VID_W-1:0] cur_nb_ff, cur_nb_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic             match_ff, match_in;
   logic             add_a_ff, add_a_in;
   logic             add_b_ff, add_b_in;
   logic             full_ff, full_in;
   logic [CNT_W-1:0] emit_ff, emit_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VID_W-1:0] rsp_neighbor_ff, rsp_neighbor_in;
   logic [RC_W-1:0]  rsp_row_count_ff, rsp_row_count_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_added_to_a_ff, rsp_added_to_a_in;
   logic             rsp_added_to_b_ff, rsp_added_to_b_in;
   logic             rsp_row_full_ff, rsp_row_full_in;

   logic [CNT_W-1:0] counts_ff [NUM_VERTICES];

   logic [VID_W-1:0] sel_v;
   logic             sel_valid;
   logic [ROW_W-1:0] sel_row;
   logic [CNT_W-1:0] sel_cnt;
   logic             skip;
   logic             hit;
   logic             scan_done;
   logic             rsp_free;
   logic             count_we;
   logic             rsp_load;

   // The count lookup follows the row being scanned, otherwise vertex_a.
   assign sel_v     = (state_ff == ST_SCAN) ? cur_v_ff : a_ff;
   assign sel_valid = vertex_valid(sel_v);
   assign sel_row   = vertex_row(sel_v);
   assign sel_cnt   = sel_valid ? counts_ff[sel_row] : '0;
   assign skip      = !sel_valid || (cur_nb_ff == '0);
   assign hit       = pend_ff && (rd_data == cur_nb_ff);
   assign scan_done = skip || ((idx_ff == sel_cnt) && !pend_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      phase_in          = phase_ff;
      cur_v_in          = cur_v_ff;
      cur_nb_in         = cur_nb_ff;
      idx_in            = idx_ff;
      pend_in           = pend_ff;
      match_in          = match_ff;
      add_a_in          = add_a_ff;
      add_b_in          = add_b_ff;
      full_in           = full_ff;
      emit_in           = emit_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_neighbor_in   = rsp_neighbor_ff;
      rsp_row_count_in  = rsp_row_count_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_added_to_a_in = rsp_added_to_a_ff;
      rsp_added_to_b_in = rsp_added_to_b_ff;
      rsp_row_full_in   = rsp_row_full_ff;
      mem_req.we        = 1'b0;
      mem_req.re        = 1'b0;
      mem_req.addr      = entry_addr(sel_row, idx_ff);
      mem_req.wdata     = cur_nb_ff;
      count_we          = 1'b0;
      rsp_load          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in      = req_vertex_a;
               b_in      = req_vertex_b;
               cur_v_in  = req_vertex_a;
               cur_nb_in = req_vertex_b;
               phase_in  = 1'b0;
               idx_in    = '0;
               pend_in   = 1'b0;
               match_in  = 1'b0;
               add_a_in  = 1'b0;
               add_b_in  = 1'b0;
               full_in   = 1'b0;
               state_in  = (req_op == OP_READ_ROW) ? ST_RD_START : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (!skip && !match_ff) begin
                  if (32'(sel_cnt) >= MAX_NEIGHBORS) begin
                     full_in = 1'b1;
                  end else begin
                     // The scan leaves idx at the row count, the first free slot.
                     mem_req.we = 1'b1;
                     count_we   = 1'b1;
                     if (phase_ff) begin
                        add_b_in = 1'b1;
                     end else begin
                        add_a_in = 1'b1;
                     end
                  end
               end
               idx_in   = '0;
               pend_in  = 1'b0;
               match_in = 1'b0;
               if (phase_ff) begin
                  state_in = ST_RESP;
               end else begin
                  cur_v_in  = b_ff;
                  cur_nb_in = a_ff;
                  phase_in  = 1'b1;
               end
            end else begin
               match_in = match_ff || hit;
               if (idx_ff != sel_cnt) begin
                  mem_req.re = 1'b1;
                  idx_in     = idx_ff + CNT_W'(1);
                  pend_in    = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         ST_RD_START: begin
            if (sel_cnt == '0) begin
               state_in = ST_RESP;
            end else begin
               emit_in    = (32'(sel_cnt) > RESULT_LIMIT) ? CNT_W'(RESULT_LIMIT) : sel_cnt;
               mem_req.re = 1'b1;
               idx_in     = CNT_W'(1);
               state_in   = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            // idx points one past the entry whose data sits in the read register.
            if (rsp_free) begin
               rsp_load          = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_neighbor_in   = rd_data;
               rsp_row_count_in  = RC_W'(sel_cnt);
               rsp_last_in       = (idx_ff == emit_ff);
               rsp_added_to_a_in = 1'b0;
               rsp_added_to_b_in = 1'b0;
               rsp_row_full_in   = 1'b0;
               if (idx_ff == emit_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_req.re = 1'b1;
                  idx_in     = idx_ff + CNT_W'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load          = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_neighbor_in   = '0;
               rsp_row_count_in  = RC_W'(sel_cnt);
               rsp_last_in       = 1'b1;
               rsp_added_to_a_in = add_a_ff;
               rsp_added_to_b_in = add_b_ff;
               rsp_row_full_in   = full_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      a_ff              <= a_in;
      b_ff              <= b_in;
      phase_ff          <= phase_in;
      cur_v_ff          <= cur_v_in;
      cur_nb_ff         <= cur_nb_in;
      idx_ff            <= idx_in;
      match_ff          <= match_in;
      add_a_ff          <= add_a_in;
      add_b_ff          <= add_b_in;
      full_ff           <= full_in;
      emit_ff           <= emit_in;
      rsp_neighbor_ff   <= rsp_neighbor_in;
      rsp_row_count_ff  <= rsp_row_count_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_added_to_a_ff <= rsp_added_to_a_in;
      rsp_added_to_b_ff <= rsp_added_to_b_in;
      rsp_row_full_ff   <= rsp_row_full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTICES; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (count_we) begin
         counts_ff[sel_row] <= sel_cnt + CNT_W'(1);
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neighbor   = rsp_neighbor_ff;
   assign rsp_row_count  = rsp_row_count_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_added_to_a = rsp_added_to_a_ff;
   assign rsp_added_to_b = rsp_added_to_b_ff;
   assign rsp_row_full   = rsp_row_full_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a request is still in progress");

   assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (!match_ff && (32'(sel_cnt) < MAX_NEIGHBORS)))
      else $error("neighbor stored into a full row or as a duplicate");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !skip) |-> (idx_ff <= sel_cnt))
      else $error("duplicate scan ran past the row count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_DATA) |-> ((idx_ff != '0) && (idx_ff <= emit_ff)))
      else $error("row read index out of range");
`endif

endmodule

### rtl/adjacency_list_builder.sv
`timescale 1ns / 1ps

// Adjacency list builder for an undirected graph of up to NUM_VERTICES vertices.
// Request channel (req_*): op 0 adds edge (vertex_a, vertex_b) to both rows,
// op 1 reads the neighbor row of vertex_a. Response channel (rsp_*): an add gives
// one response with the row count of vertex_a and the added/full flags; a read
// gives one response per stored neighbor in insertion order, or one empty
// response, with last set on the final one. Both channels use valid/ready.
// One request is processed at a time; req_ready is high only when idle.
// A single compare unit scans a row one stored neighbor per cycle from the
// neighbor RAM (one port, registered read); an empty row or a skipped insert
// ends its scan at once. An add scans the row of vertex_a, then that of
// vertex_b, then answers; a read streams its results from the RAM.
// A stalled response holds in the output register and the sequencer waits for
// it. Reset clears all row counts, so the block is ready right after reset;
// RAM contents are never read before written.

module adjacency_list_builder
   import adj_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [VID_W-1:0]     req_vertex_a,
   input  logic [VID_W-1:0]     req_vertex_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VID_W-1:0]     rsp_neighbor,
   output logic [RC_W-1:0]      rsp_row_count,
   output logic                 rsp_last,
   output logic                 rsp_added_to_a,
   output logic                 rsp_added_to_b,
   output logic                 rsp_row_full
);

   mem_req_type      mem_req;
   logic [VID_W-1:0] rd_data;

   adj_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_neighbor   (rsp_neighbor),
      .rsp_row_count  (rsp_row_count),
      .rsp_last       (rsp_last),
      .rsp_added_to_a (rsp_added_to_a),
      .rsp_added_to_b (rsp_added_to_b),
      .rsp_row_full   (rsp_row_full),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   adj_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

### tb/sv/adjacency_list_tb_pkg.sv
`timescale 1ns / 1ps

package adjacency_list_tb_pkg;
   import adj_pkg::*;

   typedef struct packed {
      logic [VID_W-1:0] neighbor;
      logic [RC_W-1:0]  row_count;
      logic             last;
      logic             added_to_a;
      logic             added_to_b;
      logic             row_full;
   } row_result_type;

endpackage

### tb/sv/adjacency_list_checker.sv
`timescale 1ns / 1ps

module adjacency_list_checker
   import adj_pkg::*, adjacency_list_tb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_op,
   input  logic [VID_W-1:0] req_vertex_a,
   input  logic [VID_W-1:0] req_vertex_b,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [VID_W-1:0] rsp_neighbor,
   input  logic [RC_W-1:0]  rsp_row_count,
   input  logic             rsp_last,
   input  logic             rsp_added_to_a,
   input  logic             rsp_added_to_b,
   input  logic             rsp_row_full,
   output int               mismatches,
   output int               pending,
   output int               edges_seen,
   output int               reads_seen,
   output int               responses_seen,
   output int               drops_seen
);

   logic [VID_W-1:0] rows [NUM_VERTICES][MAX_NEIGHBORS];
   int               row_len [NUM_VERTICES];
   row_result_type   expected_responses [$];

   function automatic bit has_row(input logic [VID_W-1:0] v);
      return v != 0 && int'(v) <= NUM_VERTICES;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] response mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string field, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
   endtask

   // Appends a neighbor to a row unless the row is missing, the id is zero,
   // the id is already there, or the row is full (which raises dropped).
   task automatic append_neighbor(input logic [VID_W-1:0] owner,
                                  input logic [VID_W-1:0] nb,
                                  output bit stored, inout bit dropped);
      int row;
      int n;
      stored = 1'b0;
      if (!has_row(owner) || nb == 0)
         return;
      row = int'(owner) - 1;
      n = row_len[row];
      for (int i = 0; i < n; i++)
         if (rows[row][i] == nb)
            return;
      if (n >= MAX_NEIGHBORS) begin
         dropped = 1'b1;
         return;
      end
      rows[row][n] = nb;
      row_len[row] = n + 1;
      stored = 1'b1;
   endtask

   task automatic predict_request(input adj_op_type op, input logic [VID_W-1:0] va,
                                  input logic [VID_W-1:0] vb);
      bit got_a;
      bit got_b;
      bit dropped;
      int n;
      int row;
      n = 0;
      row = int'(va) - 1;
      if (op == OP_ADD_EDGE) begin
         dropped = 1'b0;
         append_neighbor(va, vb, got_a, dropped);
         append_neighbor(vb, va, got_b, dropped);
         if (has_row(va))
            n = row_len[row];
         expected_responses.push_back('{neighbor: '0, row_count: RC_W'(n), last: 1'b1,
                                        added_to_a: got_a, added_to_b: got_b,
                                        row_full: dropped});
         edges_seen++;
         if (dropped)
            drops_seen++;
      end else begin
         if (has_row(va))
            n = (row_len[row] > RESULT_LIMIT) ? RESULT_LIMIT : row_len[row];
         if (n == 0)
            expected_responses.push_back('{neighbor: '0, row_count: '0, last: 1'b1,
                                           added_to_a: 1'b0, added_to_b: 1'b0,
                                           row_full: 1'b0});
         for (int k = 0; k < n; k++)
            expected_responses.push_back('{neighbor: rows[row][k], row_count: RC_W'(n),
                                           last: (k == n - 1), added_to_a: 1'b0,
                                           added_to_b: 1'b0, row_full: 1'b0});
         reads_seen++;
      end
   endtask

   task automatic check_response();
      row_result_type want;
      responses_seen++;
      if (expected_responses.size() == 0) begin
         report_mismatch($sformatf("response with none expected (neighbor %0d, last %0d)",
                                   rsp_neighbor, rsp_last));
         return;
      end
      want = expected_responses.pop_front();
      compare_field("neighbor", rsp_neighbor, want.neighbor);
      compare_field("row_count", 8'(rsp_row_count), 8'(want.row_count));
      compare_field("last", 8'(rsp_last), 8'(want.last));
      compare_field("added_to_a", 8'(rsp_added_to_a), 8'(want.added_to_a));
      compare_field("added_to_b", 8'(rsp_added_to_b), 8'(want.added_to_b));
      compare_field("row_full", 8'(rsp_row_full), 8'(want.row_full));
   endtask

   // A response taken at an edge is checked before a request accepted at that
   // edge is predicted; the response always belongs to an earlier request.
   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_VERTICES; r++)
            row_len[r] = 0;
         expected_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_response();
         if (req_valid && req_ready)
            predict_request(adj_op_type'(req_op), req_vertex_a, req_vertex_b);
      end
      pending = expected_responses.size();
   end

endmodule

### tb/sv/adjacency_list_builder_test.sv
`timescale 1ns / 1ps

module adjacency_list_builder_test;
   import adj_pkg::*;
   import adjacency_list_tb_pkg::*;

   localparam int CYCLE_LIMIT     = 400_000;
   localparam int RANDOM_REQUESTS = 460;
   localparam int HOLD_CYCLES     = 200;
   localparam int DRAIN_CYCLES    = 2 * MAX_NEIGHBORS + 10;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_op;
   logic [VID_W-1:0] req_vertex_a;
   logic [VID_W-1:0] req_vertex_b;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VID_W-1:0] rsp_neighbor;
   logic [RC_W-1:0]  rsp_row_count;
   logic             rsp_last;
   logic             rsp_added_to_a;
   logic             rsp_added_to_b;
   logic             rsp_row_full;

   int mismatches;
   int pending;
   int edges_seen;
   int reads_seen;
   int responses_seen;
   int drops_seen;

   int cycle_count = 0;
   bit steady = 1'b0;
   int hold_asks = 0;
   int hold_served = 0;
   int hold_left = 0;

   adjacency_list_builder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_neighbor   (rsp_neighbor),
      .rsp_row_count  (rsp_row_count),
      .rsp_last       (rsp_last),
      .rsp_added_to_a (rsp_added_to_a),
      .rsp_added_to_b (rsp_added_to_b),
      .rsp_row_full   (rsp_row_full)
   );

   adjacency_list_checker list_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_neighbor   (rsp_neighbor),
      .rsp_row_count  (rsp_row_count),
      .rsp_last       (rsp_last),
      .rsp_added_to_a (rsp_added_to_a),
      .rsp_added_to_b (rsp_added_to_b),
      .rsp_row_full   (rsp_row_full),
      .mismatches     (mismatches),
      .pending        (pending),
      .edges_seen     (edges_seen),
      .reads_seen     (reads_seen),
      .responses_seen (responses_seen),
      .drops_seen     (drops_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still expected",
                  cycle_count, pending);
         $display("** adjacency_list_builder: FAILED **");
         $finish;
      end
   end

   // Response side: random back-pressure, none while steady is set, and one
   // long hold-off on request so that the block backs up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 15);
      end
   end

   task automatic send_request(input adj_op_type op, input logic [VID_W-1:0] a,
                               input logic [VID_W-1:0] b);
      while (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_vertex_a <= a;
      req_vertex_b <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly edges between real vertices so rows fill up and overflow; the rest
   // mixes in arbitrary ids, zero ids and reads of real and missing vertices.
   task automatic random_request();
      int pick;
      logic [VID_W-1:0] a;
      logic [VID_W-1:0] b;
      logic [VID_W-1:0] any_id;
      pick = $urandom_range(99);
      a = VID_W'($urandom_range(1, NUM_VERTICES));
      b = VID_W'($urandom_range(1, NUM_VERTICES));
      any_id = VID_W'($urandom_range(0, 255));
      if (pick < 55)
         send_request(OP_ADD_EDGE, a, b);
      else if (pick < 65 && $urandom_range(1) == 1)
         send_request(OP_ADD_EDGE, a, any_id);
      else if (pick < 65)
         send_request(OP_ADD_EDGE, any_id, a);
      else if (pick < 70)
         send_request(OP_ADD_EDGE, any_id, VID_W'($urandom_range(0, 255)));
      else if (pick < 95)
         send_request(OP_READ_ROW, a, any_id);
      else
         send_request(OP_READ_ROW, any_id, b);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_ADD_EDGE;
      req_vertex_a = '0;
      req_vertex_b = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty and missing rows first, then the add corner cases and reads of the rows they touched.
      send_request(OP_READ_ROW, 8'd1, 8'd0);
      send_request(OP_READ_ROW, 8'd0, 8'd255);
      send_request(OP_READ_ROW, 8'd255, 8'd0);
      send_request(OP_READ_ROW, 8'd17, 8'd0);
      send_request(OP_ADD_EDGE, 8'd0, 8'd5);
      send_request(OP_ADD_EDGE, 8'd5, 8'd0);
      send_request(OP_ADD_EDGE, 8'd0, 8'd0);
      send_request(OP_ADD_EDGE, 8'd3, 8'd3);
      send_request(OP_ADD_EDGE, 8'd1, 8'd2);
      send_request(OP_ADD_EDGE, 8'd1, 8'd2);
      send_request(OP_ADD_EDGE, 8'd2, 8'd1);
      send_request(OP_ADD_EDGE, 8'd4, 8'd255);
      send_request(OP_ADD_EDGE, 8'd128, 8'd4);
      send_request(OP_ADD_EDGE, 8'd16, 8'd1);
      send_request(OP_READ_ROW, 8'd4, 8'd0);
      send_request(OP_READ_ROW, 8'd1, 8'd0);
      send_request(OP_READ_ROW, 8'd3, 8'd0);
      send_request(OP_READ_ROW, 8'd16, 8'd0);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         steady = (i >= 100 && i < 200);
         if (i == 300)
            hold_asks++;
         random_request();
      end
      req_valid <= 1'b0;

      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d edge adds (%0d dropped a neighbor on a full row)",
               edges_seen, drops_seen);
      $display("and %0d row reads; %0d responses checked, %0d mismatches",
               reads_seen, responses_seen, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("** adjacency_list_builder: PASSED **");
      else
         $display("** adjacency_list_builder: FAILED **");
      $finish;
   end

endmodule
